@@ hw/rtl/ffha_pkg.sv @@
// first-fit heap allocator: shared constants, field widths and codes
// no dependencies; imported by the top level
`timescale 1ns / 1ps

package ffha_pkg;

  // field widths of the request, result and configuration words
  localparam int FUNC_W    = 2;
  localparam int SIZE_W    = 17;
  localparam int ADDR_W    = 16;
  localparam int STAT_W    = 2;
  localparam int COPY_W    = 17;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 1;

  // default geometry
  localparam int DEF_HEAP_BYTES   = 65536;
  localparam int DEF_MAX_EXTENTS  = 64;
  localparam int DEF_HEADER_BYTES = 8;

  // extra bytes beyond the header that a split remainder must hold
  localparam int MIN_EXTRA = 16;

  // configuration reset values
  localparam logic [CFG_W-1:0] GROW_STEP_RST  = CFG_W'(16384);
  localparam logic [CFG_W-1:0] HEAP_LIMIT_RST = CFG_W'(65536);

  // request codes
  localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REALLOC = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOOP = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OOM  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GROW_STEP  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_LIMIT = 1'b1;

endpackage

@@ hw/rtl/first_fit_heap_allocator_unit.sv @@
// first-fit heap allocator: request sequencer over the extent and block-size memories
// depends on ffha_pkg and ffha_ram
`timescale 1ns / 1ps

// One request is worked at a time; a new word is taken while the previous result
// still waits at the output register. The free extents sit address-sorted in one
// memory read one entry per cycle. An allocate scans the extents, then may close up
// an exhausted extent, or grow the break and enter its tail; a free searches for
// its place, then shifts the tail at most once. A moving reallocate adds an
// allocate and a free. Block sizes live in a second memory, one entry per 8-byte
// granule. Neither memory is cleared after reset; the block accepts requests
// from the first cycle.
module first_fit_heap_allocator_unit #(
  parameter int HEAP_BYTES   = ffha_pkg::DEF_HEAP_BYTES,
  parameter int MAX_EXTENTS  = ffha_pkg::DEF_MAX_EXTENTS,
  parameter int HEADER_BYTES = ffha_pkg::DEF_HEADER_BYTES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ffha_pkg::FUNC_W-1:0]   func,
  input  logic [ffha_pkg::SIZE_W-1:0]   size,
  input  logic [ffha_pkg::ADDR_W-1:0]   addr,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ffha_pkg::STAT_W-1:0]   status,
  output logic [ffha_pkg::ADDR_W-1:0]   result_addr,
  output logic [ffha_pkg::COPY_W-1:0]   copy_bytes,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ffha_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ffha_pkg::CFG_W-1:0]    cfg_data
);

  import ffha_pkg::*;

  localparam int HEAP_W = $clog2(HEAP_BYTES) + 1;
  localparam int W      = (HEAP_W > SIZE_W + 1) ? HEAP_W : SIZE_W + 1;
  localparam int XW     = $clog2(MAX_EXTENTS);
  localparam int CW     = $clog2(MAX_EXTENTS + 1);
  localparam int GR     = HEAP_BYTES / 8;
  localparam int GW     = $clog2(GR);

  localparam logic [W-1:0]  HEAP_V  = W'(HEAP_BYTES);
  localparam logic [W-1:0]  HDR_V   = W'(HEADER_BYTES);
  localparam logic [W-1:0]  MINR_V  = W'(HEADER_BYTES + MIN_EXTRA);
  localparam logic [W-1:0]  RND_V   = W'(7);
  localparam logic [W:0]    LEN_MAX = (W+1)'(2 * HEAP_BYTES - 1);
  localparam logic [CW-1:0] MAXE_C  = CW'(MAX_EXTENTS);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_DISP  = 14'b00000000000010,
    S_F_RD  = 14'b00000000000100,
    S_F_CHK = 14'b00000000001000,
    S_A_BEG = 14'b00000000010000,
    S_A_SCN = 14'b00000000100000,
    S_A_TAK = 14'b00000001000000,
    S_G_CLC = 14'b00000010000000,
    S_G_DEC = 14'b00000100000000,
    S_I_SCN = 14'b00001000000000,
    S_I_ACT = 14'b00010000000000,
    S_SHL   = 14'b00100000000000,
    S_SHR   = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } state_t;

  function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = (s > LEN_MAX) ? LEN_MAX[W-1:0] : s[W-1:0];
  endfunction

  state_t state;

  // request and configuration registers
  logic [FUNC_W-1:0] req_func;
  logic [SIZE_W-1:0] req_size;
  logic [ADDR_W-1:0] req_addr;
  logic [CFG_W-1:0]  grow_step;
  logic [CFG_W-1:0]  heap_limit;
  logic              chk_re;
  logic              moving;
  logic [W-1:0]      old_copy;
  logic [W-1:0]      need;

  // table state
  logic [CW-1:0] count;
  logic [W-1:0]  brk;

  // scan and shift pipeline
  logic [CW-1:0] scan_idx;
  logic          pend;
  logic [XW-1:0] pend_idx;
  logic [W-1:0]  hit_s, hit_l;
  logic [XW-1:0] hit_idx;
  logic [W-1:0]  cur_s, cur_l, prev_s, prev_l;
  logic          has_cur, has_prev;
  logic [CW-1:0] pos;
  logic [W-1:0]  ins_b, ins_len;
  logic          ins_grow;
  logic          shl_ins;

  // growth
  logic [W-1:0] cand, room, base, chunk;
  logic         over;

  // result
  logic [STAT_W-1:0] res_status;
  logic [W-1:0]      res_addr, res_copy;

  // memory ports
  logic            ext_we;
  logic [XW-1:0]   ext_wa, ext_ra;
  logic [2*W-1:0]  ext_wd, ext_rdata;
  logic            sz_we;
  logic [GW-1:0]   sz_wa, sz_ra;
  logic [W-1:0]    sz_wd, sz_rdata;
  logic [W-1:0]    sz_wstart;

  logic [W-1:0] rd_s, rd_l;
  assign rd_s = ext_rdata[2*W-1:W];
  assign rd_l = ext_rdata[W-1:0];

  // request address decode
  logic [W-1:0] a_w, blk, old_len, need_min;
  logic         addr_ok;
  assign a_w      = W'(req_addr);
  assign blk      = a_w - HDR_V;
  assign addr_ok  = (a_w >= HDR_V) && (blk[2:0] == 3'd0) && (blk < HEAP_V);
  assign sz_ra    = blk[GW+2:3];
  assign old_len  = (sz_rdata > HDR_V) ? sz_rdata - HDR_V : '0;
  assign need_min = need + MINR_V;

  // scan events
  logic scan_more, a_hit, i_stop, shl_done, shr_more, shr_done;
  assign scan_more = scan_idx < count;
  assign a_hit     = (state == S_A_SCN) && pend && (rd_l >= need);
  assign i_stop    = (state == S_I_SCN) && pend && (rd_s >= ins_b);
  assign shl_done  = (state == S_SHL) && !pend && !scan_more;
  assign shr_more  = scan_idx > pos;
  assign shr_done  = (state == S_SHR) && !pend && !shr_more;

  // merge decision
  logic fwd, bwd;
  assign fwd = has_cur && (({1'b0, ins_b} + {1'b0, ins_len}) == {1'b0, cur_s});
  assign bwd = has_prev && (({1'b0, prev_s} + {1'b0, prev_l}) == {1'b0, ins_b});

  // growth decision
  logic         g_fit1, g_fit2;
  logic [W-1:0] g_c;
  assign g_fit1 = !over && (cand <= room);
  assign g_fit2 = !over && (need <= room);
  assign g_c    = g_fit1 ? cand : need;

  // insert completion and allocate completion events
  logic         ins_fin, ins_ok, adone;
  logic [W-1:0] adone_addr;
  always_comb begin
    ins_fin = 1'b0;
    ins_ok  = 1'b1;
    if (state == S_I_ACT) begin
      if (!(fwd && bwd)) begin
        if (fwd || bwd) begin
          ins_fin = 1'b1;
        end else if (count >= MAXE_C) begin
          ins_fin = 1'b1;
          ins_ok  = 1'b0;
        end
      end
    end else if (shl_done && shl_ins) begin
      ins_fin = 1'b1;
    end else if (shr_done) begin
      ins_fin = 1'b1;
    end
  end

  always_comb begin
    adone      = 1'b0;
    adone_addr = '0;
    if (state == S_A_TAK && hit_l >= need_min) begin
      adone      = 1'b1;
      adone_addr = hit_s + HDR_V;
    end else if (shl_done && !shl_ins) begin
      adone      = 1'b1;
      adone_addr = hit_s + HDR_V;
    end else if (state == S_G_DEC && (g_fit1 || g_fit2) && g_c < need_min) begin
      adone      = 1'b1;
      adone_addr = brk + HDR_V;
    end else if (ins_fin && ins_grow) begin
      adone      = 1'b1;
      adone_addr = base + HDR_V;
    end
  end

  // extent memory control
  always_comb begin
    ext_ra = (state == S_SHR) ? XW'(scan_idx - ONE_C) : scan_idx[XW-1:0];
    ext_we = 1'b0;
    ext_wa = '0;
    ext_wd = '0;
    if (state == S_A_TAK && hit_l >= need_min) begin
      ext_we = 1'b1;
      ext_wa = hit_idx;
      ext_wd = {hit_s + need, hit_l - need};
    end else if (state == S_I_ACT && bwd) begin
      ext_we = 1'b1;
      ext_wa = XW'(pos - ONE_C);
      ext_wd = {prev_s, fwd ? sat_add(prev_l, sat_add(ins_len, cur_l))
                            : sat_add(prev_l, ins_len)};
    end else if (state == S_I_ACT && fwd) begin
      ext_we = 1'b1;
      ext_wa = pos[XW-1:0];
      ext_wd = {ins_b, sat_add(cur_l, ins_len)};
    end else if (state == S_SHL && pend) begin
      ext_we = 1'b1;
      ext_wa = pend_idx - XW'(1);
      ext_wd = ext_rdata;
    end else if (state == S_SHR && pend) begin
      ext_we = 1'b1;
      ext_wa = pend_idx + XW'(1);
      ext_wd = ext_rdata;
    end else if (shr_done) begin
      ext_we = 1'b1;
      ext_wa = pos[XW-1:0];
      ext_wd = {ins_b, ins_len};
    end
  end

  // block-size memory write
  always_comb begin
    sz_we     = 1'b0;
    sz_wstart = '0;
    sz_wd     = '0;
    if (state == S_A_TAK) begin
      sz_we     = 1'b1;
      sz_wstart = hit_s;
      sz_wd     = (hit_l >= need_min) ? need : hit_l;
    end else if (state == S_G_DEC && (g_fit1 || g_fit2) && g_c < need_min) begin
      sz_we     = 1'b1;
      sz_wstart = brk;
      sz_wd     = g_c;
    end else if (ins_fin && ins_grow) begin
      sz_we     = 1'b1;
      sz_wstart = base;
      sz_wd     = ins_ok ? need : chunk;
    end
    if (sz_wstart >= HEAP_V) begin
      sz_we = 1'b0;
    end
    sz_wa = sz_wstart[GW+2:3];
  end

  ffha_ram #(.WIDTH(2 * W), .DEPTH(MAX_EXTENTS)) u_ext_ram (
    .clk   (clk),
    .we    (ext_we),
    .waddr (ext_wa),
    .wdata (ext_wd),
    .raddr (ext_ra),
    .rdata (ext_rdata)
  );

  ffha_ram #(.WIDTH(W), .DEPTH(GR)) u_size_ram (
    .clk   (clk),
    .we    (sz_we),
    .waddr (sz_wa),
    .wdata (sz_wd),
    .raddr (sz_ra),
    .rdata (sz_rdata)
  );

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grow_step  <= GROW_STEP_RST;
      heap_limit <= HEAP_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GROW_STEP:  grow_step  <= cfg_data;
        REG_HEAP_LIMIT: heap_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // growth arithmetic
  logic [W-1:0] g_lim, g_gc;
  assign g_lim = (W'(heap_limit) < HEAP_V) ? W'(heap_limit) : HEAP_V;
  assign g_gc  = (W'(grow_step) + RND_V) & ~RND_V;

  // request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      brk       <= '0;
      pend      <= 1'b0;
      moving    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_func   <= func;
            req_size   <= size;
            req_addr   <= addr;
            res_status <= STAT_OK;
            res_addr   <= '0;
            res_copy   <= '0;
            moving     <= 1'b0;
            chk_re     <= 1'b0;
            state      <= S_DISP;
          end
        end
        S_DISP: begin
          unique case (req_func)
            FUNC_ALLOC: state <= S_A_BEG;
            FUNC_FREE: begin
              if (req_addr == '0) begin
                res_status <= STAT_NOOP;
                state      <= S_DONE;
              end else begin
                state <= S_F_RD;
              end
            end
            FUNC_REALLOC: begin
              if (req_addr == '0) begin
                state <= S_A_BEG;
              end else begin
                chk_re <= (req_size != '0);
                state  <= S_F_RD;
              end
            end
            default: begin
              res_status <= STAT_NOOP;
              state      <= S_DONE;
            end
          endcase
        end
        S_F_RD: begin
          if (!addr_ok) begin
            res_status <= STAT_NOOP;
            state      <= S_DONE;
          end else begin
            state <= S_F_CHK;
          end
        end
        S_F_CHK: begin
          if (sz_rdata == '0) begin
            res_status <= moving ? STAT_OK : STAT_NOOP;
            state      <= S_DONE;
          end else if (chk_re && !moving) begin
            if (old_len >= W'(req_size)) begin
              res_status <= STAT_OK;
              res_addr   <= a_w;
              state      <= S_DONE;
            end else begin
              moving   <= 1'b1;
              old_copy <= old_len;
              state    <= S_A_BEG;
            end
          end else begin
            ins_b    <= blk;
            ins_len  <= sz_rdata;
            ins_grow <= 1'b0;
            scan_idx <= '0;
            pend     <= 1'b0;
            has_prev <= 1'b0;
            state    <= S_I_SCN;
          end
        end
        S_A_BEG: begin
          if (req_size == '0) begin
            res_status <= STAT_NOOP;
            state      <= S_DONE;
          end else if (W'(req_size) > HEAP_V) begin
            res_status <= STAT_OOM;
            state      <= S_DONE;
          end else begin
            need     <= HDR_V + ((W'(req_size) + RND_V) & ~RND_V);
            scan_idx <= '0;
            pend     <= 1'b0;
            state    <= S_A_SCN;
          end
        end
        // one extent per cycle, result of the previous read checked
        S_A_SCN: begin
          if (a_hit) begin
            hit_s   <= rd_s;
            hit_l   <= rd_l;
            hit_idx <= pend_idx;
            pend    <= 1'b0;
            state   <= S_A_TAK;
          end else if (scan_more) begin
            pend     <= 1'b1;
            pend_idx <= scan_idx[XW-1:0];
            scan_idx <= scan_idx + ONE_C;
          end else begin
            pend  <= 1'b0;
            state <= S_G_CLC;
          end
        end
        S_A_TAK: begin
          if (hit_l < need_min) begin
            scan_idx <= CW'(hit_idx) + ONE_C;
            pend     <= 1'b0;
            shl_ins  <= 1'b0;
            state    <= S_SHL;
          end
        end
        S_G_CLC: begin
          cand  <= (need > g_gc) ? need : g_gc;
          room  <= g_lim - brk;
          over  <= brk > g_lim;
          state <= S_G_DEC;
        end
        S_G_DEC: begin
          if (!(g_fit1 || g_fit2)) begin
            res_status <= STAT_OOM;
            state      <= S_DONE;
          end else begin
            brk   <= brk + g_c;
            base  <= brk;
            chunk <= g_c;
            if (g_c >= need_min) begin
              ins_b    <= brk + need;
              ins_len  <= g_c - need;
              ins_grow <= 1'b1;
              scan_idx <= '0;
              pend     <= 1'b0;
              has_prev <= 1'b0;
              state    <= S_I_SCN;
            end
          end
        end
        // find the first extent at or above the block
        S_I_SCN: begin
          if (i_stop) begin
            pos     <= CW'(pend_idx);
            cur_s   <= rd_s;
            cur_l   <= rd_l;
            has_cur <= 1'b1;
            pend    <= 1'b0;
            state   <= S_I_ACT;
          end else begin
            if (pend) begin
              prev_s   <= rd_s;
              prev_l   <= rd_l;
              has_prev <= 1'b1;
            end
            if (scan_more) begin
              pend     <= 1'b1;
              pend_idx <= scan_idx[XW-1:0];
              scan_idx <= scan_idx + ONE_C;
            end else begin
              pos     <= count;
              has_cur <= 1'b0;
              pend    <= 1'b0;
              state   <= S_I_ACT;
            end
          end
        end
        S_I_ACT: begin
          if (fwd && bwd) begin
            scan_idx <= pos + ONE_C;
            pend     <= 1'b0;
            shl_ins  <= 1'b1;
            state    <= S_SHL;
          end else if (!fwd && !bwd && count < MAXE_C) begin
            scan_idx <= count;
            pend     <= 1'b0;
            state    <= S_SHR;
          end
        end
        // close up one entry: read j+1, then write j from the registered read data
        S_SHL: begin
          if (scan_more) begin
            pend     <= 1'b1;
            pend_idx <= scan_idx[XW-1:0];
            scan_idx <= scan_idx + ONE_C;
          end else begin
            pend <= 1'b0;
          end
          if (shl_done) begin
            count <= count - ONE_C;
          end
        end
        // open a slot at pos: read i-1, then write i from the registered read data
        S_SHR: begin
          if (shr_more) begin
            pend     <= 1'b1;
            pend_idx <= XW'(scan_idx - ONE_C);
            scan_idx <= scan_idx - ONE_C;
          end else begin
            pend <= 1'b0;
          end
          if (shr_done) begin
            count <= count + ONE_C;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            status      <= res_status;
            result_addr <= res_addr[ADDR_W-1:0];
            copy_bytes  <= res_copy[COPY_W-1:0];
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // free finished its insert
      if (ins_fin && !ins_grow) begin
        res_status <= ins_ok ? STAT_OK : STAT_FULL;
        state      <= S_DONE;
      end

      // allocate granted: done, or go on to free the old block of a moving reallocate
      if (adone) begin
        res_addr <= adone_addr;
        if (moving) begin
          res_copy <= old_copy;
          state    <= S_F_RD;
        end else begin
          res_status <= STAT_OK;
          state      <= S_DONE;
        end
      end
    end
  end

  // table never holds more entries than it has room for
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= MAXE_C)
    else $error("extent count beyond table size");

  // break stays inside the heap
  a_brk_range: assert property (@(posedge clk) disable iff (rst)
    brk <= HEAP_V)
    else $error("break pointer beyond heap");

  // a new result only follows the hand-off state
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result raised outside hand-off");

  // memories are not written between requests
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!ext_we && !sz_we))
    else $error("memory write while idle");

endmodule

@@ hw/rtl/ffha_ram.sv @@
// generic simple dual-port RAM, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
